FILE: hdl/tpc_pkg.sv
// Shared types, constants and helpers for the triangle plane clipper.
package tpc_pkg;

    localparam int COORD_W  = 32;
    localparam int TDATA_W  = 9 * COORD_W;
    localparam int PROD_W   = 2 * COORD_W;
    // plane value: three exact products plus the shifted offset
    localparam int PLANE_W  = PROD_W + 2;
    // divider datapath: denominator and shifted remainder
    localparam int DIV_W    = PLANE_W + 2;
    localparam int ALPHA_W  = 31;
    localparam int CNT_W    = 5;
    localparam int CFG_AW   = 3;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = 1;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] REG_NORMAL_X     = 3'd0;
    localparam logic [CFG_AW-1:0] REG_NORMAL_Y     = 3'd1;
    localparam logic [CFG_AW-1:0] REG_NORMAL_Z     = 3'd2;
    localparam logic [CFG_AW-1:0] REG_PLANE_OFFSET = 3'd3;

    localparam logic signed [COORD_W-1:0] NORMAL_Z_RESET = 32'sd65536;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [PLANE_W-1:0] plane_t;

    // x in the lowest bits
    typedef struct packed {
        coord_t z;
        coord_t y;
        coord_t x;
    } vert_t;

    typedef vert_t [2:0] tri_t;

    // one classified triangle waiting for the back end
    typedef struct packed {
        tri_t         verts;
        plane_t [2:0] sval;
        logic [2:0]   outm;
    } job_t;

    // lowest set bit of a three-bit mask
    function automatic logic [1:0] first_set(input logic [2:0] m);
        logic [1:0] r;
        if (m[0]) begin
            r = 2'd0;
        end else if (m[1]) begin
            r = 2'd1;
        end else begin
            r = 2'd2;
        end
        return r;
    endfunction

    // highest set bit of a three-bit mask
    function automatic logic [1:0] last_set(input logic [2:0] m);
        logic [1:0] r;
        if (m[2]) begin
            r = 2'd2;
        end else if (m[1]) begin
            r = 2'd1;
        end else begin
            r = 2'd0;
        end
        return r;
    endfunction

endpackage

FILE: hdl/triangle_plane_clipper.sv
// Triangle clipper against one plane: top level.
// A triangle fully inside passes straight through; a clipped one has each cut edge
// divided in the shared restoring divider, with setup, multiply, add and output steps.
// The back end works on one triangle at a time; the front end and the two-entry queue
// take further triangles while it is busy, until the queue fills.
// Reset (aresetn, synchronous, active low) empties the queue and output register
// and sets the plane to normal (0, 0, 1.0), offset 0.
module triangle_plane_clipper (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [tpc_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [tpc_pkg::COORD_W-1:0]   cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z
    input  logic [tpc_pkg::TDATA_W-1:0]   s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_v0_x, out_v0_y, out_v0_z, out_v1_x, ..., out_v2_z
    output logic [tpc_pkg::TDATA_W-1:0]   m_tdata,
    output logic                          m_tlast
);
    import tpc_pkg::*;

    logic q_push, q_full, q_valid, q_ready;
    job_t push_job, pop_job;

    tpc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_push    (q_push),
        .q_job     (push_job),
        .q_full    (q_full)
    );

    tpc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop_ready (q_ready),
        .pop_job   (pop_job)
    );

    tpc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_job    (pop_job),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: hdl/tpc_front.sv
// Front end: plane registers, vertex classification and queue push.
module tpc_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [tpc_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [tpc_pkg::COORD_W-1:0]   cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tpc_pkg::TDATA_W-1:0]   s_tdata,
    output logic                          q_push,
    output tpc_pkg::job_t                 q_job,
    input  logic                          q_full
);
    import tpc_pkg::*;

    coord_t normal_x_reg, normal_y_reg, normal_z_reg, offset_reg;
    logic   st_valid_reg;
    tri_t   tri_reg;
    coord_t offset_st_reg;
    logic signed [PROD_W-1:0] prod_reg [3][3];
    tri_t   tri_in;

    assign tri_in = tri_t'(s_tdata);

    // plane registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            normal_x_reg <= '0;
            normal_y_reg <= '0;
            normal_z_reg <= NORMAL_Z_RESET;
            offset_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_NORMAL_X:     normal_x_reg <= cfg_wdata;
                REG_NORMAL_Y:     normal_y_reg <= cfg_wdata;
                REG_NORMAL_Z:     normal_z_reg <= cfg_wdata;
                REG_PLANE_OFFSET: offset_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign q_push   = st_valid_reg && !q_full;
    assign s_tready = !st_valid_reg || !q_full;

    // product stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else if (s_tready) begin
            st_valid_reg <= s_tvalid;
        end
    end

    // register exact products for each vertex
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            tri_reg       <= tri_in;
            offset_st_reg <= offset_reg;
            for (int v = 0; v < 3; v++) begin
                prod_reg[v][0] <= tri_in[v].x * normal_x_reg;
                prod_reg[v][1] <= tri_in[v].y * normal_y_reg;
                prod_reg[v][2] <= tri_in[v].z * normal_z_reg;
            end
        end
    end

    // sum plane values and classify
    always_comb begin
        plane_t off_ext;
        off_ext = {{(PLANE_W-COORD_W-16){offset_st_reg[COORD_W-1]}}, offset_st_reg, 16'b0};
        q_job.verts = tri_reg;
        for (int v = 0; v < 3; v++) begin
            q_job.sval[v] = PLANE_W'(prod_reg[v][0]) + PLANE_W'(prod_reg[v][1])
                          + PLANE_W'(prod_reg[v][2]) + off_ext;
            q_job.outm[v] = q_job.sval[v][PLANE_W-1];
        end
    end

endmodule

FILE: hdl/tpc_queue.sv
// Two-entry queue between front and back end.
module tpc_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  tpc_pkg::job_t  push_job,
    output logic           full,
    output logic           pop_valid,
    input  logic           pop_ready,
    output tpc_pkg::job_t  pop_job
);
    import tpc_pkg::*;

    job_t               mem [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]    count_reg;
    logic               pop;

    assign full      = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop       = pop_valid && pop_ready;
    assign pop_job   = mem[rd_ptr_reg];

    // store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    // advance pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: hdl/tpc_back.sv
// Back end: edge intersections by iterative division and result output.
module tpc_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  tpc_pkg::job_t                 q_job,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tpc_pkg::TDATA_W-1:0]   m_tdata,
    output logic                          m_tlast
);
    import tpc_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PASS  = 3'd1;
    localparam logic [2:0] S_SETUP = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_ADD   = 3'd5;
    localparam logic [2:0] S_EMIT1 = 3'd6;
    localparam logic [2:0] S_EMIT2 = 3'd7;

    logic [2:0]          state_reg, state_next;
    job_t                job_reg;
    logic                phase_reg;
    logic [1:0]          ia_reg, ib_reg;
    logic [DIV_W-1:0]    den_reg, rem_reg;
    logic [ALPHA_W-1:0]  quo_reg;
    logic [CNT_W-1:0]    cnt_reg;
    coord_t              term_reg [3];
    vert_t               x_reg, y_reg;
    logic                m_valid_reg;
    tri_t                m_tri_reg;
    logic                m_last_reg;

    logic [2:0]          inm;
    logic [1:0]          nout;
    logic [1:0]          i_first, i_last, o_first, o_last;
    logic [1:0]          ia_sel, ib_sel;
    logic                can_load;
    logic [DIV_W-1:0]    rem2;
    logic                ge;
    vert_t               va, vb, res;
    logic signed [DIV_W-1:0] sa_ext, sb_ext;

    assign inm     = ~job_reg.outm;
    assign nout    = {1'b0, job_reg.outm[0]} + {1'b0, job_reg.outm[1]}
                   + {1'b0, job_reg.outm[2]};
    assign i_first = first_set(inm);
    assign i_last  = last_set(inm);
    assign o_first = first_set(job_reg.outm);
    assign o_last  = last_set(job_reg.outm);

    // edge for this phase: inside end, outside end
    always_comb begin
        if (!phase_reg) begin
            ia_sel = (nout == 2'd1) ? i_last : i_first;
            ib_sel = o_first;
        end else begin
            ia_sel = i_first;
            ib_sel = (nout == 2'd1) ? o_first : o_last;
        end
    end

    assign sa_ext = DIV_W'(job_reg.sval[ia_sel]);
    assign sb_ext = DIV_W'(job_reg.sval[ib_sel]);

    assign can_load = !m_valid_reg || m_tready;
    assign q_ready  = (state_reg == S_IDLE);
    assign rem2     = {rem_reg[DIV_W-2:0], 1'b0};
    assign ge       = (rem2 >= den_reg);
    assign va       = job_reg.verts[ia_reg];
    assign vb       = job_reg.verts[ib_reg];

    always_comb begin
        res.x = va.x + term_reg[0];
        res.y = va.y + term_reg[1];
        res.z = va.z + term_reg[2];
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    state_next = S_PASS;
                    if (q_job.outm == 3'b111) begin
                        state_next = S_IDLE;
                    end else if (q_job.outm != 3'b000) begin
                        state_next = S_SETUP;
                    end
                end
            end
            S_PASS:  if (can_load) state_next = S_IDLE;
            S_SETUP: state_next = S_DIV;
            S_DIV:   if (cnt_reg == CNT_W'(ALPHA_W - 1)) state_next = S_MUL;
            S_MUL:   state_next = S_ADD;
            S_ADD: begin
                if (!phase_reg) begin
                    state_next = S_SETUP;
                end else begin
                    state_next = (nout == 2'd1) ? S_EMIT1 : S_EMIT2;
                end
            end
            S_EMIT1: if (can_load) state_next = S_EMIT2;
            S_EMIT2: if (can_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (can_load && (state_reg == S_PASS || state_reg == S_EMIT1
                             || state_reg == S_EMIT2)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                job_reg   <= q_job;
                phase_reg <= 1'b0;
            end
            S_SETUP: begin
                ia_reg  <= ia_sel;
                ib_reg  <= ib_sel;
                den_reg <= sa_ext - sb_ext;
                rem_reg <= sa_ext;
                quo_reg <= '0;
                cnt_reg <= '0;
            end
            S_DIV: begin
                rem_reg <= ge ? (rem2 - den_reg) : rem2;
                quo_reg <= {quo_reg[ALPHA_W-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
            end
            S_MUL: begin
                logic signed [COORD_W:0]     dx, dy, dz;
                logic signed [ALPHA_W:0]     al;
                logic signed [PROD_W:0]      px, py, pz;
                dx = (COORD_W+1)'(vb.x) - (COORD_W+1)'(va.x);
                dy = (COORD_W+1)'(vb.y) - (COORD_W+1)'(va.y);
                dz = (COORD_W+1)'(vb.z) - (COORD_W+1)'(va.z);
                al = {1'b0, quo_reg};
                px = al * dx;
                py = al * dy;
                pz = al * dz;
                // floor of product over 2^31, low bits only
                term_reg[0] <= px[ALPHA_W+COORD_W-1:ALPHA_W];
                term_reg[1] <= py[ALPHA_W+COORD_W-1:ALPHA_W];
                term_reg[2] <= pz[ALPHA_W+COORD_W-1:ALPHA_W];
            end
            S_ADD: begin
                if (!phase_reg) begin
                    x_reg <= res;
                end else begin
                    y_reg <= res;
                end
                phase_reg <= 1'b1;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (can_load) begin
            unique case (state_reg)
                S_PASS: begin
                    m_tri_reg  <= job_reg.verts;
                    m_last_reg <= 1'b1;
                end
                S_EMIT1: begin
                    m_tri_reg  <= {x_reg, job_reg.verts[i_last], job_reg.verts[i_first]};
                    m_last_reg <= 1'b0;
                end
                S_EMIT2: begin
                    m_tri_reg  <= {y_reg, x_reg, job_reg.verts[i_first]};
                    m_last_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tri_reg;
    assign m_tlast  = m_last_reg;

endmodule
